### rtl/jbec_pkg.sv
package jbec_pkg;

    localparam int COEF_W   = 11;
    localparam int VAL_W    = 12;
    localparam int IDX_W    = 8;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int CAT_W    = 4;
    localparam int POS_W    = 6;
    localparam int DC_AW    = 4;
    localparam int DC_DEPTH = 16;
    localparam int AC_DEPTH = 256;
    localparam int ENTRY_W  = LEN_W + CODE_W;

    localparam logic [1:0] MODE_COEF    = 2'd0;
    localparam logic [1:0] MODE_LOAD_DC = 2'd1;
    localparam logic [1:0] MODE_LOAD_AC = 2'd2;

    localparam logic [IDX_W-1:0] SYM_ZRL = 8'hF0;
    localparam logic [IDX_W-1:0] SYM_EOB = 8'h00;

    localparam logic [POS_W-1:0] RUN_LIMIT = 6'd15;
    localparam logic [POS_W-1:0] RUN_STEP  = 6'd16;
    localparam logic [LEN_W-1:0] LEN_MAX   = 5'd16;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [CODE_W-1:0] code;
    } code_entry_t;

endpackage

### rtl/jbec_ram.sv
module jbec_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/jbec_alu.sv
module jbec_alu (
    input  logic                               op,
    input  logic signed [jbec_pkg::VAL_W-1:0]  a,
    input  logic signed [jbec_pkg::VAL_W-1:0]  b,
    output logic signed [jbec_pkg::VAL_W-1:0]  sum,
    output logic        [jbec_pkg::CAT_W-1:0]  cat
);
    import jbec_pkg::*;

    always_comb begin
        if (op == ALU_SUB) begin
            sum = a - b;
        end else begin
            sum = a + b;
        end
    end

    // bit length of a non-negative result, used as the size category
    always_comb begin
        cat = '0;
        for (int i = 0; i < VAL_W - 1; i++) begin
            if (sum[i]) begin
                cat = CAT_W'(i + 1);
            end
        end
    end

endmodule

### rtl/jpeg_block_entropy_coder_top.sv
// JPEG baseline run-length and Huffman symbol coder.
// Input stream: one transaction per item. s_tuser holds the mode (coefficient,
// DC table load, AC table load). Coefficients arrive in zigzag order,
// BLOCK_COEFFICIENTS per block; the first of each block is coded against the
// previous DC value through the DC table, later nonzero ones as (run, size)
// symbols through the AC table, with ZRL and EOB symbols where needed.
// Output stream: one transaction per code word with its amplitude bits;
// m_tuser flags a table entry that was never loaded, m_tlast marks the final
// result of an input item.
// Steps: a table load is written as it is accepted. A coefficient passes
// through the difference, magnitude and amplitude states, then, if it gives a
// result, the table read and emit states, going back to the amplitude state
// after each ZRL, and ends in the finish state; these steps share one
// 12-bit add/subtract unit and a registered table read.
// s_tready is low while a coefficient is in work. Results sit in an output
// register; when the receiver stalls, the block waits there before the next
// result and resumes as soon as the register is taken.
// Reset clears the DC predictor, block position and zero run, drops m_tvalid,
// then runs a clearing pass over both tables with s_tready low.
module jpeg_block_entropy_coder_top #(
    parameter int BLOCK_COEFFICIENTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // coefficient, table_index, table_code, table_length
    input  logic [39:0] s_tdata,
    // mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // code_value, code_length, extra_value, extra_length, zero pad
    output logic [39:0] m_tdata,
    // code_missing
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);
    import jbec_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIFF  = 3'd1;
    localparam logic [2:0] S_ABS   = 3'd2;
    localparam logic [2:0] S_AMP   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;
    localparam logic [2:0] S_CLEAR = 3'd7;

    localparam logic [1:0] KIND_DC  = 2'd0;
    localparam logic [1:0] KIND_AC  = 2'd1;
    localparam logic [1:0] KIND_ZRL = 2'd2;
    localparam logic [1:0] KIND_EOB = 2'd3;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_COEFFICIENTS - 1);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(AC_DEPTH - 1);

    // input fields
    logic [1:0]               in_mode;
    logic signed [COEF_W-1:0] in_coef;
    logic [IDX_W-1:0]         in_idx;
    logic [CODE_W-1:0]        in_code;
    logic [LEN_W-1:0]         in_len;
    code_entry_t              load_entry;

    assign in_mode = s_tuser;
    assign in_coef = s_tdata[10:0];
    assign in_idx  = s_tdata[18:11];
    assign in_code = s_tdata[34:19];
    assign in_len  = s_tdata[39:35];

    always_comb begin
        load_entry.code   = in_code;
        load_entry.length = (in_len > LEN_MAX) ? LEN_MAX : in_len;
    end

    logic [2:0]               state_reg, state_next;
    logic signed [COEF_W-1:0] coef_reg, coef_next;
    logic signed [COEF_W-1:0] pred_reg, pred_next;
    logic signed [VAL_W-1:0]  val_reg, val_next;
    logic [CAT_W-1:0]         cat_reg, cat_next;
    logic [COEF_W-1:0]        amp_reg, amp_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         run_reg, run_next;
    logic [1:0]               kind_reg, kind_next;
    logic [IDX_W-1:0]         addr_reg, addr_next;
    logic [IDX_W-1:0]         clr_addr_reg, clr_addr_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [CODE_W-1:0]        out_code_reg, out_code_next;
    logic [LEN_W-1:0]         out_len_reg, out_len_next;
    logic [COEF_W-1:0]        out_xv_reg, out_xv_next;
    logic [CAT_W-1:0]         out_xl_reg, out_xl_next;
    logic                     out_miss_reg, out_miss_next;
    logic                     out_last_reg, out_last_next;

    logic                     accept;
    logic                     clearing;
    logic                     dc_we, ac_we;
    logic [IDX_W-1:0]         ram_waddr;
    code_entry_t              ram_wdata;
    code_entry_t              dc_rd, ac_rd, rd_entry;
    logic [ENTRY_W-1:0]       dc_rdata, ac_rdata;
    logic [LEN_W-1:0]         rd_len;
    logic                     out_free;

    logic                     alu_op;
    logic signed [VAL_W-1:0]  alu_a, alu_b, alu_sum;
    logic [CAT_W-1:0]         alu_cat;
    logic                     val_neg;
    logic [VAL_W:0]           mask_wide;
    logic [VAL_W-1:0]         amp_mask;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign clearing  = (state_reg == S_CLEAR);
    assign dc_we     = clearing ||
                       (accept && (in_mode == MODE_LOAD_DC) && (in_idx < IDX_W'(DC_DEPTH)));
    assign ac_we     = clearing || (accept && (in_mode == MODE_LOAD_AC));
    assign ram_waddr = clearing ? clr_addr_reg : in_idx;
    assign ram_wdata = clearing ? '0 : load_entry;
    assign val_neg   = val_reg[VAL_W-1];
    assign out_free  = !m_tvalid_reg || m_tready;

    assign mask_wide = ({{VAL_W{1'b0}}, 1'b1} << cat_reg) - {{VAL_W{1'b0}}, 1'b1};
    assign amp_mask  = mask_wide[VAL_W-1:0];

    jbec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DC_DEPTH)
    ) u_dc_ram (
        .aclk  (aclk),
        .we    (dc_we),
        .waddr (ram_waddr[DC_AW-1:0]),
        .wdata (ram_wdata),
        .raddr (addr_reg[DC_AW-1:0]),
        .rdata (dc_rdata)
    );

    jbec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (AC_DEPTH)
    ) u_ac_ram (
        .aclk  (aclk),
        .we    (ac_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ac_rdata)
    );

    assign dc_rd = dc_rdata;
    assign ac_rd = ac_rdata;

    // a zero length marks an entry that was never loaded
    always_comb begin
        if (kind_reg == KIND_DC) begin
            rd_entry = dc_rd;
        end else begin
            rd_entry = ac_rd;
        end
        rd_len = rd_entry.length;
    end

    jbec_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .cat (alu_cat)
    );

    // operand selection for the shared adder
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_DIFF: begin
                alu_op = ALU_SUB;
                alu_a  = VAL_W'(coef_reg);
                alu_b  = (pos_reg == '0) ? VAL_W'(pred_reg) : '0;
            end
            S_ABS: begin
                // magnitude: val - 0 or 0 - val
                alu_op = ALU_SUB;
                alu_a  = val_neg ? '0 : val_reg;
                alu_b  = val_neg ? val_reg : '0;
            end
            S_AMP: begin
                // one's complement of negatives: val + 2^cat - 1
                alu_op = ALU_ADD;
                alu_a  = val_reg;
                alu_b  = val_neg ? amp_mask : '0;
            end
            S_EMIT: begin
                alu_op = ALU_SUB;
                alu_a  = VAL_W'(run_reg);
                alu_b  = VAL_W'(RUN_STEP);
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        coef_next     = coef_reg;
        pred_next     = pred_reg;
        val_next      = val_reg;
        cat_next      = cat_reg;
        amp_next      = amp_reg;
        pos_next      = pos_reg;
        run_next      = run_reg;
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        clr_addr_next = clr_addr_reg;
        m_tvalid_next = m_tvalid_reg;
        out_code_next = out_code_reg;
        out_len_next  = out_len_reg;
        out_xv_next   = out_xv_reg;
        out_xl_next   = out_xl_reg;
        out_miss_next = out_miss_reg;
        out_last_next = out_last_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && (in_mode == MODE_COEF)) begin
                    coef_next  = in_coef;
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                val_next = alu_sum;
                if (pos_reg == '0) begin
                    pred_next = coef_reg;
                end
                state_next = S_ABS;
            end
            S_ABS: begin
                cat_next   = alu_cat;
                state_next = S_AMP;
            end
            S_AMP: begin
                amp_next   = alu_sum[COEF_W-1:0];
                state_next = S_RD;
                if (pos_reg == '0) begin
                    kind_next = KIND_DC;
                    addr_next = IDX_W'(cat_reg);
                end else if (val_reg == '0) begin
                    kind_next = KIND_EOB;
                    addr_next = SYM_EOB;
                    if (pos_reg < POS_LAST) begin
                        state_next = S_FIN;
                    end
                end else if (run_reg > RUN_LIMIT) begin
                    kind_next = KIND_ZRL;
                    addr_next = SYM_ZRL;
                end else begin
                    kind_next = KIND_AC;
                    addr_next = {run_reg[3:0], cat_reg};
                end
            end
            S_RD: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_len_next  = rd_len;
                    out_code_next = (rd_len != '0) ? rd_entry.code : '0;
                    out_miss_next = (rd_len == '0);
                    out_last_next = (kind_reg != KIND_ZRL);
                    if (kind_reg == KIND_DC || kind_reg == KIND_AC) begin
                        out_xv_next = amp_reg;
                        out_xl_next = cat_reg;
                    end else begin
                        out_xv_next = '0;
                        out_xl_next = '0;
                    end
                    if (kind_reg == KIND_ZRL) begin
                        run_next   = alu_sum[POS_W-1:0];
                        state_next = S_AMP;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (pos_reg >= POS_LAST) begin
                    pos_next = '0;
                    run_next = '0;
                end else begin
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == '0 || coef_reg != '0) begin
                        run_next = '0;
                    end else begin
                        run_next = run_reg + 1'b1;
                    end
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            pred_reg     <= '0;
            pos_reg      <= '0;
            run_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pred_reg     <= pred_next;
            pos_reg      <= pos_next;
            run_reg      <= run_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        coef_reg     <= coef_next;
        val_reg      <= val_next;
        cat_reg      <= cat_next;
        amp_reg      <= amp_next;
        kind_reg     <= kind_next;
        addr_reg     <= addr_next;
        out_code_reg <= out_code_next;
        out_len_reg  <= out_len_next;
        out_xv_reg   <= out_xv_next;
        out_xl_reg   <= out_xl_next;
        out_miss_reg <= out_miss_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_xl_reg, out_xv_reg, out_len_reg, out_code_reg};
    assign m_tuser  = out_miss_reg;
    assign m_tlast  = out_last_reg;

    // only ZRL results are not last, and they carry no amplitude bits
    a_zrl_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[35:21] == '0))
        else $error("non-last result carries amplitude bits");

    a_missing_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[20:0] == '0))
        else $error("missing entry with nonzero code");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg < POS_LAST)
        else $error("zero run exceeds block length");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("block position out of range");

endmodule
